// ----- hdl/sww_pkg.sv -----
// Shared constants and helper functions for the spike waveform width block.
package sww_pkg;

  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_PEAK_WINDOW = 32;
  localparam int DEF_FRAC_BITS   = 8;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int CFG_W    = 7;
  localparam int WIDTH_W  = 15;
  localparam int POS_W    = 5;

  localparam logic [CFG_W-1:0]   COUNT_RESET = 7'd32;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 15'h7FFF;

  // Magnitude of a signed sample; the most negative value gives 32768.
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [SAMPLE_W-1:0] x);
    logic [SAMPLE_W:0] e;
    e = {x[SAMPLE_W-1], x};
    if (e[SAMPLE_W]) begin
      e = -e;
    end
    return e[MAG_W-1:0];
  endfunction

  // Magnitude of the difference of two samples; it always fits in 16 bits.
  function automatic logic [MAG_W-1:0] mag_diff(input logic signed [SAMPLE_W-1:0] a,
                                                input logic signed [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0] d;
    d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    if (d[SAMPLE_W]) begin
      d = -d;
    end
    return d[MAG_W-1:0];
  endfunction

endpackage

// ----- hdl/spike_waveform_width_top.sv -----
// Spike waveform width: top level with loader, search sequencer and serial divider.
// Samples are taken one per cycle while loading; C samples make one waveform.
// After the last sample the block is busy with two searches and up to two divisions: the two
// searches read one sample a cycle and together cover the waveform once, and each division
// yields FRAC_BITS quotient bits. The final state waits until an earlier result is taken.
// Reset (synchronous) sets the sample count to 32 and empties the waveform and the peak.
module spike_waveform_width_top #(
  parameter int MAX_SAMPLES = sww_pkg::DEF_MAX_SAMPLES,
  parameter int PEAK_WINDOW = sww_pkg::DEF_PEAK_WINDOW,
  parameter int FRAC_BITS   = sww_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [sww_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  logic signed [sww_pkg::SAMPLE_W-1:0] sample,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [sww_pkg::WIDTH_W-1:0]        width_q8,
  output logic [sww_pkg::POS_W-1:0]          peak_position
);

  import sww_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int QW = CW + FRAC_BITS + 1;
  localparam int SW = $clog2(FRAC_BITS);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_BSTART = 4'd1;
  localparam logic [3:0] S_BCUR   = 4'd2;
  localparam logic [3:0] S_BPREV  = 4'd3;
  localparam logic [3:0] S_FSTART = 4'd4;
  localparam logic [3:0] S_FPREV  = 4'd5;
  localparam logic [3:0] S_FCUR   = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]           state;
  logic [CFG_W-1:0]     sample_count;
  logic [CW-1:0]        fill_count;
  logic [MAG_W-1:0]     peak_magnitude;
  logic [IW-1:0]        peak_index;
  logic [CW-1:0]        t;
  logic signed [SAMPLE_W-1:0] held;
  logic [MAG_W-1:0]     rem;
  logic [MAG_W-1:0]     den;
  logic [FRAC_BITS-1:0] quo;
  logic [SW-1:0]        step;
  logic                 div_fwd;
  logic [QW-1:0]        pre_q;
  logic [QW-1:0]        post_q;

  logic [CW-1:0]        cnt;
  logic [31:0]          cfg_ext;
  logic                 accept;
  logic [MAG_W-1:0]     in_mag;
  logic                 take_peak;
  logic [CW-1:0]        fill_inc;
  logic [IW-1:0]        peak_idx_new;
  logic [CW-1:0]        fwd_start;
  logic [IW-1:0]        rd_addr;
  logic [SAMPLE_W-1:0]  rd_word;
  logic signed [SAMPLE_W-1:0] rd_sample;
  logic signed [SAMPLE_W-1:0] unit_a;
  logic signed [SAMPLE_W-1:0] unit_b;
  logic [MAG_W-1:0]     unit_mag;
  logic [MAG_W-1:0]     unit_dif;
  logic                 unit_cross;
  logic [MAG_W:0]       div_shift;
  logic                 div_ge;
  logic [MAG_W-1:0]     rem_next;
  logic [FRAC_BITS-1:0] quo_next;
  logic [QW-1:0]        t_q;
  logic [QW-1:0]        cnt_q;
  logic [QW-1:0]        span;
  logic [WIDTH_W-1:0]   width_sat;
  logic                 out_free;

  // Effective count: the register clamped to the range two to MAX_SAMPLES.
  always_comb begin
    cfg_ext = 32'(sample_count);
    if (cfg_ext < 32'd2) begin
      cnt = CW'(2);
    end else if (cfg_ext > 32'(MAX_SAMPLES)) begin
      cnt = CW'(MAX_SAMPLES);
    end else begin
      cnt = CW'(sample_count);
    end
  end

  assign sample_ready = (state == S_LOAD);
  assign accept       = sample_valid && sample_ready;

  assign in_mag       = mag_of(sample);
  assign take_peak    = (32'(fill_count) < 32'(PEAK_WINDOW)) && (in_mag > peak_magnitude);
  assign fill_inc     = fill_count + CW'(1);
  assign peak_idx_new = take_peak ? IW'(fill_count) : peak_index;
  assign fwd_start    = (peak_index == '0) ? CW'(1) : CW'(peak_index);

  always_comb begin
    unique case (state)
      S_BSTART: rd_addr = t[IW-1:0];
      S_BCUR:   rd_addr = IW'(t - CW'(1));
      S_BPREV:  rd_addr = IW'(t - CW'(2));
      S_FSTART: rd_addr = IW'(fwd_start - CW'(1));
      S_FPREV:  rd_addr = t[IW-1:0];
      S_FCUR:   rd_addr = IW'(t + CW'(1));
      default:  rd_addr = t[IW-1:0];
    endcase
  end

  sww_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (fill_count[IW-1:0]),
    .wr_data (sample),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_sample = signed'(rd_word);

  // Shared crossing test: the current sample against its earlier neighbour.
  always_comb begin
    if (state == S_FCUR) begin
      unit_a = rd_sample;
      unit_b = held;
    end else begin
      unit_a = held;
      unit_b = rd_sample;
    end
  end

  assign unit_mag   = mag_of(unit_a);
  assign unit_dif   = mag_diff(unit_a, unit_b);
  assign unit_cross = unit_dif > unit_mag;

  // One restoring division step; the divisor always exceeds the dividend.
  assign div_shift = {rem, 1'b0};
  assign div_ge    = div_shift >= {1'b0, den};
  assign rem_next  = div_ge ? MAG_W'(div_shift - {1'b0, den}) : div_shift[MAG_W-1:0];
  assign quo_next  = {quo[FRAC_BITS-2:0], div_ge};

  assign t_q   = QW'({t, {FRAC_BITS{1'b0}}});
  assign cnt_q = QW'({cnt, {FRAC_BITS{1'b0}}});
  assign span  = post_q - pre_q;

  always_comb begin
    if (post_q < pre_q) begin
      width_sat = '0;
    end else if (32'(span) > 32'(WIDTH_MAX)) begin
      width_sat = WIDTH_MAX;
    end else begin
      width_sat = WIDTH_W'(span);
    end
  end

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      sample_count   <= COUNT_RESET;
      fill_count     <= '0;
      peak_magnitude <= '0;
      peak_index     <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            fill_count <= fill_inc;
            if (take_peak) begin
              peak_magnitude <= in_mag;
            end
            peak_index <= peak_idx_new;
            t          <= CW'(peak_idx_new);
            if (fill_inc >= cnt) begin
              state <= S_BSTART;
            end
          end
        end
        S_BSTART: begin
          if (t == '0) begin
            pre_q <= '0;
            state <= S_FSTART;
          end else begin
            state <= S_BCUR;
          end
        end
        S_BCUR: begin
          held  <= rd_sample;
          state <= S_BPREV;
        end
        S_BPREV: begin
          if (unit_cross) begin
            rem     <= unit_mag;
            den     <= unit_dif;
            step    <= '0;
            div_fwd <= 1'b0;
            state   <= S_DIV;
          end else if (t == CW'(1)) begin
            pre_q <= '0;
            state <= S_FSTART;
          end else begin
            held <= rd_sample;
            t    <= t - CW'(1);
          end
        end
        S_FSTART: begin
          t <= fwd_start;
          if (fwd_start >= cnt) begin
            post_q <= cnt_q;
            state  <= S_FIN;
          end else begin
            state <= S_FPREV;
          end
        end
        S_FPREV: begin
          held  <= rd_sample;
          state <= S_FCUR;
        end
        S_FCUR: begin
          if (unit_cross) begin
            rem     <= unit_mag;
            den     <= unit_dif;
            step    <= '0;
            div_fwd <= 1'b1;
            state   <= S_DIV;
          end else if (t + CW'(1) >= cnt) begin
            post_q <= cnt_q;
            state  <= S_FIN;
          end else begin
            held <= rd_sample;
            t    <= t + CW'(1);
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          step <= step + SW'(1);
          if (step == SW'(FRAC_BITS - 1)) begin
            if (div_fwd) begin
              post_q <= t_q + QW'(quo_next);
              state  <= S_FIN;
            end else begin
              pre_q <= t_q - QW'(quo_next);
              state <= S_FSTART;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            width_q8       <= width_sat;
            peak_position  <= POS_W'(32'(peak_index));
            result_valid   <= 1'b1;
            fill_count     <= '0;
            peak_magnitude <= '0;
            peak_index     <= '0;
            state          <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
      // A new sample count discards any partly loaded waveform.
      if (cfg_wr_en) begin
        sample_count   <= cfg_wr_data;
        fill_count     <= '0;
        peak_magnitude <= '0;
        peak_index     <= '0;
      end
    end
  end

endmodule

// ----- hdl/sww_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sww_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- test/spike_width_checker.sv -----
// Checker that predicts the spike width results and compares them with the block's output.
`timescale 1ns / 1ps
module spike_width_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [sww_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                sample_valid,
  input  logic                                sample_ready,
  input  logic signed [sww_pkg::SAMPLE_W-1:0] sample,
  input  logic                                result_valid,
  input  logic                                result_ready,
  input  logic [sww_pkg::WIDTH_W-1:0]         width_q8,
  input  logic [sww_pkg::POS_W-1:0]           peak_position,
  output int                                  n_fail,
  output int                                  outstanding
);

  import sww_pkg::*;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [POS_W-1:0]   pos;
  } spike_width_t;

  spike_width_t pending_widths[$];
  spike_width_t oldest;

  logic signed [SAMPLE_W-1:0] wave [DEF_MAX_SAMPLES];
  logic [CFG_W-1:0]           count_reg;
  int                         fill;
  int                         top_mag;
  int                         top_idx;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int active_count(input logic [CFG_W-1:0] c);
    if (c < 2) return 2;
    if (c > DEF_MAX_SAMPLES) return DEF_MAX_SAMPLES;
    return int'(c);
  endfunction

  // The step is always larger than the magnitude here, so this is a pure fraction.
  function automatic int crossing_frac(input int m, input int d);
    return (m << DEF_FRAC_BITS) / d;
  endfunction

  task automatic clear_wave();
    fill    = 0;
    top_mag = 0;
    top_idx = 0;
  endtask

  // Takes one accepted sample and queues a result when it completes the waveform.
  task automatic measure_width(input logic signed [SAMPLE_W-1:0] s);
    int n, t, m, d, cur, prv, pre_q, post_q, w;
    bit hit;
    spike_width_t r;
    n   = active_count(count_reg);
    cur = s;
    wave[fill] = s;
    if (fill < ((n < DEF_PEAK_WINDOW) ? n : DEF_PEAK_WINDOW) && magnitude(cur) > top_mag) begin
      top_mag = magnitude(cur);
      top_idx = fill;
    end
    fill++;
    if (fill < n) return;

    pre_q = 0;
    hit   = 1'b0;
    for (t = top_idx; t > 0 && !hit; t--) begin
      cur = wave[t];
      prv = wave[t-1];
      m   = magnitude(cur);
      d   = magnitude(cur - prv);
      if (d > m) begin
        pre_q = (t << DEF_FRAC_BITS) - crossing_frac(m, d);
        hit   = 1'b1;
      end
    end

    // The forward search never starts at sample 0, which has no predecessor.
    post_q = n << DEF_FRAC_BITS;
    hit    = 1'b0;
    for (t = (top_idx > 0) ? top_idx : 1; t < n && !hit; t++) begin
      cur = wave[t];
      prv = wave[t-1];
      m   = magnitude(cur);
      d   = magnitude(prv - cur);
      if (d > m) begin
        post_q = (t << DEF_FRAC_BITS) + crossing_frac(m, d);
        hit    = 1'b1;
      end
    end

    w = post_q - pre_q;
    if (w < 0) w = 0;
    r.width = (w > int'(WIDTH_MAX)) ? WIDTH_MAX : w[WIDTH_W-1:0];
    r.pos   = top_idx[POS_W-1:0];
    pending_widths.push_back(r);
    clear_wave();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count_reg = COUNT_RESET;
      clear_wave();
      pending_widths.delete();
      n_fail = 0;
    end else begin
      // Results are checked before the sample of this edge can add a new expectation.
      if (result_valid && result_ready) begin
        if (pending_widths.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, width_q8 %0d peak_position %0d",
                   $time, width_q8, peak_position);
        end else begin
          oldest = pending_widths.pop_front();
          if (width_q8 !== oldest.width) begin
            n_fail++;
            $display("%0t: width_q8 expected %0d, got %0d", $time, oldest.width, width_q8);
          end
          if (peak_position !== oldest.pos) begin
            n_fail++;
            $display("%0t: peak_position expected %0d, got %0d",
                     $time, oldest.pos, peak_position);
          end
        end
      end
      if (cfg_wr_en) begin
        count_reg = cfg_wr_data;
        clear_wave();
      end
      if (sample_valid && sample_ready) begin
        measure_width(sample);
      end
    end
    outstanding <= pending_widths.size();
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the spike waveform width block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb;
  import sww_pkg::*;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       cfg_wr_en    = 1'b0;
  logic [CFG_W-1:0]           cfg_wr_data  = '0;
  logic                       sample_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] sample       = '0;
  logic                       result_ready = 1'b0;
  logic                       sample_ready;
  logic                       result_valid;
  logic [WIDTH_W-1:0]         width_q8;
  logic [POS_W-1:0]           peak_position;

  int n_fail;
  int outstanding;
  int src_idle  = 0;
  int sink_idle = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= sink_idle);
  end

  spike_waveform_width_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .width_q8      (width_q8),
    .peak_position (peak_position)
  );

  spike_width_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .width_q8      (width_q8),
    .peak_position (peak_position),
    .n_fail        (n_fail),
    .outstanding   (outstanding)
  );

  task automatic push(input logic [SAMPLE_W-1:0] v);
    while ($urandom_range(0, 99) < src_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= v;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // The block may still be busy on its last waveform, so allow its full latency first.
  task automatic set_count(input logic [CFG_W-1:0] c);
    drain();
    repeat (150) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic int active_count(input logic [CFG_W-1:0] c);
    if (c < 2) return 2;
    if (c > DEF_MAX_SAMPLES) return DEF_MAX_SAMPLES;
    return int'(c);
  endfunction

  // Most waveforms are spikes on a quiet baseline; the rest are noise or extreme values.
  task automatic send_wave(input int n);
    int kind, centre, amp, hw, k, gap, v;
    kind   = $urandom_range(0, 9);
    centre = $urandom_range(0, n - 1);
    hw     = $urandom_range(1, 4);
    amp    = $urandom_range(100, 32767);
    if ($urandom_range(0, 1)) amp = -amp;
    if ($urandom_range(0, 15) == 0) amp = -32768;
    for (k = 0; k < n; k++) begin
      if (kind < 2) begin
        v = int'($urandom_range(0, 65535)) - 32768;
      end else if (kind == 2) begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
      end else begin
        gap = (k > centre) ? k - centre : centre - k;
        if (gap < hw) v = amp * (hw - gap) / hw;
        else if (gap == hw) v = -amp / 4;
        else v = 0;
        v = v + int'($urandom_range(0, 40)) - 20;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      push(v[SAMPLE_W-1:0]);
    end
  endtask

  // A segment may end with a part-loaded waveform, which the next register write discards.
  task automatic run_segment(input logic [CFG_W-1:0] c, input int items);
    int n, sent, tail, k;
    set_count(c);
    n    = active_count(c);
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 24) == 0) drain();
      send_wave(n);
      sent += n;
    end
    tail = $urandom_range(0, n - 1);
    for (k = 0; k < tail; k++) push(SAMPLE_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    int src_pct[3];
    int sink_pct[3];
    logic [CFG_W-1:0] seg_count[9];
    src_pct   = '{27, 56, 0};
    sink_pct  = '{56, 27, 0};
    seg_count = '{7'd64, 7'd2, 7'd20, 7'd127, 7'd33, 7'd9, 7'd0, 7'd32, 7'd2};
    seg_count[8] = CFG_W'($urandom_range(2, 64));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Values below two act as two: extremes, the most negative sample and a zero window.
    set_count(7'd0);
    push(16'h7FFF); push(16'h8000);
    push(16'h8000); push(16'h7FFF);
    push(16'h0000); push(16'h0000);
    push(16'h7FFF); push(16'h0000);
    push(16'hFFFF); push(16'h0001);
    // A flat waveform has no crossing on either side.
    set_count(7'd1);
    push(16'd5); push(16'd5);
    // A write in the middle of a waveform throws the loaded samples away.
    set_count(7'd5);
    push(16'd100); push(16'd200); push(16'd300);
    set_count(7'd3);
    push(-16'sd50); push(16'd100); push(-16'sd30);
    push(16'd7); push(16'd7); push(16'd7);

    for (int p = 0; p < 3; p++) begin
      src_idle  = src_pct[p];
      sink_idle <= sink_pct[p];
      for (int j = 0; j < 3; j++) run_segment(seg_count[p * 3 + j], 110);
    end

    drain();
    repeat (150) @(posedge clk);
    if (n_fail == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
